// ===== rtl/core/afr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_pkg
// Shared constants, codes and types for the addressed frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam logic [7:0] SYNC_BYTE   = 8'hFF;
	localparam logic [7:0] CODE_SENDER = 8'hA1;
	localparam logic [7:0] CODE_RECV   = 8'hA2;
	localparam logic [7:0] CODE_CHECK  = 8'hA3;
	localparam logic [8:0] SUM_MOD     = 9'd255;

	// parse phases
	localparam logic [2:0] PH_SYNC1  = 3'd0;
	localparam logic [2:0] PH_SYNC2  = 3'd1;
	localparam logic [2:0] PH_SENDER = 3'd2;
	localparam logic [2:0] PH_RECV   = 3'd3;
	localparam logic [2:0] PH_LENH   = 3'd4;
	localparam logic [2:0] PH_LENL   = 3'd5;
	localparam logic [2:0] PH_DATA   = 3'd6;
	localparam logic [2:0] PH_CHECK  = 3'd7;

	// event codes
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_DATA   = 3'd1;
	localparam logic [2:0] EV_GOOD   = 3'd2;
	localparam logic [2:0] EV_BADSND = 3'd3;
	localparam logic [2:0] EV_BADRCV = 3'd4;
	localparam logic [2:0] EV_BADSUM = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARTNER_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REJECT_EN  = 2'd2;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [15:0] frame_length;
		logic        reject_valid;
		logic [7:0]  reject_code;
		logic [15:0] good_frame_count;
	} afr_result_t;

	// running checksum, kept reduced mod 255
	function automatic logic [7:0] add_sum(input logic [7:0] s, input logic [7:0] b);
		logic [8:0] t;
		t = {1'b0, s} + {1'b0, b};
		if (t >= SUM_MOD) begin
			t = t - SUM_MOD;
		end
		return t[7:0];
	endfunction

endpackage

// ===== rtl/core/afr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_in_if
// Received byte channel: valid/ready with one byte of payload.
// ----------------------------------------------------------------------------
interface afr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/afr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_out_if
// Parser result channel: valid/ready with event, payload and status fields.
// ----------------------------------------------------------------------------
interface afr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [15:0] frame_length;
	logic        reject_valid;
	logic [7:0]  reject_code;
	logic [15:0] good_frame_count;

	modport source (
		output valid, output event_res, output payload_byte, output payload_index,
		output frame_length, output reject_valid, output reject_code,
		output good_frame_count, input ready
	);
	modport sink (
		input valid, input event_res, input payload_byte, input payload_index,
		input frame_length, input reject_valid, input reject_code,
		input good_frame_count, output ready
	);
endinterface

// ===== rtl/core/addressed_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressed_frame_receiver_top
// Byte-serial parser for FF FF sender receiver len_hi len_lo payload.. sum
// frames; streams payload bytes and reports frame status per byte.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  rx      | in  | valid / ready  | rx_byte
//  res     | out | valid / ready  | event_res .. good_frame_count
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
//
// Every accepted byte yields exactly one result, registered at acceptance and offered in the next cycle.
// A byte is taken every cycle while the result register is empty or being
// drained, so throughput is one byte per cycle; a stalled result holds rx.
// Parser state updates at acceptance, in a single pass of short logic.
// Reset puts the parser in sync hunt, clears counters and sets ids to 0
// with reject replies enabled.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_top
	import afr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	afr_in_if.sink               rx,
	afr_out_if.source            res
);

	logic [7:0]  own_id_q;
	logic [7:0]  partner_id_q;
	logic        reject_en_q;

	logic [2:0]  phase_q;
	logic [7:0]  sum_q;
	logic [15:0] len_q;
	logic [15:0] seen_q;
	logic [15:0] ok_q;

	logic        out_valid_q;
	afr_result_t res_q;

	logic [2:0]  phase_d;
	logic [7:0]  sum_d;
	logic [15:0] len_d;
	logic [15:0] seen_d;
	logic [15:0] ok_d;
	afr_result_t res_d;
	logic [7:0]  code;
	logic [7:0]  b;
	logic [7:0]  sum_add;
	logic        take;

	assign rx.ready = !out_valid_q || res.ready;
	assign take     = rx.valid && rx.ready;
	assign b        = rx.rx_byte;
	assign sum_add  = add_sum(sum_q, b);

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		len_d   = len_q;
		seen_d  = seen_q;
		ok_d    = ok_q;
		code    = 8'h00;
		res_d   = '0;
		case (phase_q)
			PH_SYNC1: begin
				if (b == SYNC_BYTE) begin
					sum_d   = add_sum(8'h00, b);
					len_d   = 16'h0000;
					seen_d  = 16'h0000;
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (b == SYNC_BYTE) begin
					sum_d   = sum_add;
					phase_d = PH_SENDER;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_SENDER: begin
				if (b == partner_id_q) begin
					sum_d   = sum_add;
					phase_d = PH_RECV;
				end else begin
					res_d.event_res = EV_BADSND;
					code            = CODE_SENDER;
					phase_d         = PH_SYNC1;
				end
			end
			PH_RECV: begin
				if (b == own_id_q) begin
					sum_d   = sum_add;
					phase_d = PH_LENH;
				end else begin
					res_d.event_res = EV_BADRCV;
					code            = CODE_RECV;
					phase_d         = PH_SYNC1;
				end
			end
			PH_LENH: begin
				sum_d   = sum_add;
				len_d   = {b, 8'h00};
				phase_d = PH_LENL;
			end
			PH_LENL: begin
				sum_d   = sum_add;
				len_d   = {len_q[15:8], b};
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				sum_d               = sum_add;
				res_d.event_res     = EV_DATA;
				res_d.payload_byte  = b;
				res_d.payload_index = seen_q;
				seen_d              = seen_q + 16'd1;
				// zero length still takes one byte: seen+1 >= 0 always holds
				if (seen_d >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (b == sum_q) begin
					res_d.event_res = EV_GOOD;
					ok_d            = ok_q + 16'd1;
				end else begin
					res_d.event_res = EV_BADSUM;
					code            = CODE_CHECK;
				end
				sum_d   = 8'h00;
				phase_d = PH_SYNC1;
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
		res_d.frame_length     = len_d;
		res_d.good_frame_count = ok_d;
		res_d.reject_valid     = (code != 8'h00) && reject_en_q;
		res_d.reject_code      = res_d.reject_valid ? code : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= 8'h00;
			partner_id_q <= 8'h00;
			reject_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_ID:     own_id_q     <= cfg_data;
				REG_PARTNER_ID: partner_id_q <= cfg_data;
				REG_REJECT_EN:  reject_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC1;
			sum_q       <= 8'h00;
			len_q       <= 16'h0000;
			seen_q      <= 16'h0000;
			ok_q        <= 16'h0000;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				sum_q   <= sum_d;
				len_q   <= len_d;
				seen_q  <= seen_d;
				ok_q    <= ok_d;
			end
			if (rx.ready) begin
				out_valid_q <= rx.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.event_res        = res_q.event_res;
	assign res.payload_byte     = res_q.payload_byte;
	assign res.payload_index    = res_q.payload_index;
	assign res.frame_length     = res_q.frame_length;
	assign res.reject_valid     = res_q.reject_valid;
	assign res.reject_code      = res_q.reject_code;
	assign res.good_frame_count = res_q.good_frame_count;

endmodule

// ===== sim/afr_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_frame_checker
// Watches the rx, result and register-write ports of the frame receiver,
// runs its own copy of the byte parser on every accepted rx request and
// compares each accepted result against the oldest queued parser output.
// ----------------------------------------------------------------------------
module afr_frame_checker
	import afr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	afr_in_if                    rx,
	afr_out_if                   res,
	output int                   errors,
	output int                   pending
);

	// register copies
	logic [7:0]  node_id;
	logic [7:0]  peer_id;
	logic        nak_enable;

	// parser copy
	logic [2:0]  phase;
	logic [7:0]  csum;
	logic [15:0] decl_len;
	logic [15:0] taken;
	logic [15:0] good_cnt;

	afr_result_t parser_outputs [$];
	afr_result_t oldest;

	function automatic logic [7:0] sum_mod255(input logic [7:0] s, input logic [7:0] b);
		return 8'((int'(s) + int'(b)) % 255);
	endfunction

	// one parser step; updates the parser copy and returns what the block should emit
	function automatic afr_result_t parse_rx_byte(input logic [7:0] b);
		afr_result_t r;
		logic [7:0]  code;
		r    = '0;
		code = 8'h00;
		case (phase)
			PH_SYNC1: begin
				if (b == SYNC_BYTE) begin
					csum     = sum_mod255(8'h00, b);
					decl_len = '0;
					taken    = '0;
					phase    = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (b == SYNC_BYTE) begin
					csum  = sum_mod255(csum, b);
					phase = PH_SENDER;
				end else begin
					phase = PH_SYNC1;
				end
			end
			PH_SENDER: begin
				if (b == peer_id) begin
					csum  = sum_mod255(csum, b);
					phase = PH_RECV;
				end else begin
					r.event_res = EV_BADSND;
					code        = CODE_SENDER;
					phase       = PH_SYNC1;
				end
			end
			PH_RECV: begin
				if (b == node_id) begin
					csum  = sum_mod255(csum, b);
					phase = PH_LENH;
				end else begin
					r.event_res = EV_BADRCV;
					code        = CODE_RECV;
					phase       = PH_SYNC1;
				end
			end
			PH_LENH: begin
				csum     = sum_mod255(csum, b);
				decl_len = {b, 8'h00};
				phase    = PH_LENL;
			end
			PH_LENL: begin
				csum     = sum_mod255(csum, b);
				decl_len = decl_len | {8'h00, b};
				phase    = PH_DATA;
			end
			PH_DATA: begin
				csum            = sum_mod255(csum, b);
				r.event_res     = EV_DATA;
				r.payload_byte  = b;
				r.payload_index = taken;
				taken           = taken + 16'd1;
				// zero length still takes one byte: 1 >= 0
				if (taken >= decl_len) begin
					phase = PH_CHECK;
				end
			end
			default: begin
				if (b == csum) begin
					r.event_res = EV_GOOD;
					good_cnt    = good_cnt + 16'd1;
				end else begin
					r.event_res = EV_BADSUM;
					code        = CODE_CHECK;
				end
				csum  = 8'h00;
				phase = PH_SYNC1;
			end
		endcase
		r.frame_length     = decl_len;
		r.reject_valid     = (code != 8'h00) && nak_enable;
		r.reject_code      = r.reject_valid ? code : 8'h00;
		r.good_frame_count = good_cnt;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id    = 8'h00;
			peer_id    = 8'h00;
			nak_enable = 1'b1;
			phase      = PH_SYNC1;
			csum       = 8'h00;
			decl_len   = '0;
			taken      = '0;
			good_cnt   = '0;
			parser_outputs.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (parser_outputs.size() == 0) begin
					$error("result accepted with no request outstanding");
					errors++;
				end else begin
					oldest = parser_outputs.pop_front();
					check_field("event_res", 16'(oldest.event_res), 16'(res.event_res));
					check_field("payload_byte", 16'(oldest.payload_byte), 16'(res.payload_byte));
					check_field("payload_index", oldest.payload_index, res.payload_index);
					check_field("frame_length", oldest.frame_length, res.frame_length);
					check_field("reject_valid", 16'(oldest.reject_valid), 16'(res.reject_valid));
					check_field("reject_code", 16'(oldest.reject_code), 16'(res.reject_code));
					check_field("good_frame_count", oldest.good_frame_count,
						res.good_frame_count);
				end
			end
			if (rx.valid && rx.ready) begin
				parser_outputs.push_back(parse_rx_byte(rx.rx_byte));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_OWN_ID:     node_id = cfg_data;
					REG_PARTNER_ID: peer_id = cfg_data;
					REG_REJECT_EN:  nak_enable = cfg_data[0];
					default: ;
				endcase
			end
			pending = parser_outputs.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Frame receiver bench: directed sync/id/checksum cases, then six phases of
// random frames and noise under different register settings and idle mixes.
// ----------------------------------------------------------------------------
module tb_top
	import afr_pkg::*;
;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_BYTES   = 240;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	int          src_idle;
	int          dst_idle;
	int          sent_count;
	int          target;
	int          phase_no;
	int          sel;
	logic [7:0]  cur_own;
	logic [7:0]  cur_partner;
	logic [7:0]  frame_payload [$];

	afr_in_if  rx_ch ();
	afr_out_if res_ch ();

	addressed_frame_receiver_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.res       (res_ch)
	);

	afr_frame_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx        (rx_ch),
		.res       (res_ch),
		.errors    (fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL addressed_frame_receiver_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= dst_idle);
	end

	function automatic logic [7:0] pick_other(input logic [7:0] x);
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		while (v == x) v = 8'($urandom_range(0, 255));
		return v;
	endfunction

	function automatic logic [15:0] rand_len();
		if ($urandom_range(0, 99) < 6) begin
			return 16'($urandom_range(13, 80));
		end
		return 16'($urandom_range(0, 12));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (src_idle > 0 && $urandom_range(0, 99) < src_idle) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		sent_count++;
	endtask

	// payload comes from frame_payload, topped up with random bytes
	task automatic send_frame(input logic [7:0] snd, input logic [7:0] rcv,
			input logic [15:0] len, input bit bad_sum);
		logic [7:0]  fb [$];
		logic [7:0]  cksum;
		int          n;
		int          total;
		n = (len == 16'd0) ? 1 : int'(len);
		while (frame_payload.size() < n) frame_payload.push_back(8'($urandom_range(0, 255)));
		fb = '{SYNC_BYTE, SYNC_BYTE, snd, rcv, len[15:8], len[7:0]};
		foreach (frame_payload[i]) fb.push_back(frame_payload[i]);
		frame_payload.delete();
		total = 0;
		foreach (fb[i]) total += int'(fb[i]);
		cksum = 8'(total % 255);
		fb.push_back(bad_sum ? pick_other(cksum) : cksum);
		foreach (fb[i]) send_byte(fb[i]);
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] own, input logic [7:0] partner, input bit rej);
		rx_ch.valid <= 1'b0;
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_OWN_ID;
		cfg_data  <= own;
		@(posedge clk);
		cfg_index <= REG_PARTNER_ID;
		cfg_data  <= partner;
		@(posedge clk);
		cfg_index <= REG_REJECT_EN;
		cfg_data  <= {7'($urandom_range(0, 127)), rej};
		@(posedge clk);
		// index past the register list must be ignored
		cfg_index <= REG_UNUSED;
		cfg_data  <= 8'($urandom_range(0, 255));
		@(posedge clk);
		cfg_we      <= 1'b0;
		cur_own     = own;
		cur_partner = partner;
	endtask

	task automatic send_unit();
		sel = $urandom_range(0, 99);
		if (sel < 68) begin
			send_frame(cur_partner, cur_own, rand_len(), 1'b0);
		end else if (sel < 76) begin
			send_frame(cur_partner, cur_own, rand_len(), 1'b1);
		end else if (sel < 83) begin
			send_byte(SYNC_BYTE);
			send_byte(SYNC_BYTE);
			send_byte(pick_other(cur_partner));
		end else if (sel < 89) begin
			send_byte(SYNC_BYTE);
			send_byte(SYNC_BYTE);
			send_byte(cur_partner);
			send_byte(pick_other(cur_own));
		end else if (sel < 94) begin
			send_byte(SYNC_BYTE);
			send_byte(pick_other(SYNC_BYTE));
		end else begin
			// line noise while hunting; no sync byte so framing stays aligned
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_OWN_ID;
		cfg_data      <= 8'h00;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		src_idle      = 28;
		dst_idle      = 53;
		sent_count    = 0;
		cur_own       = 8'h00;
		cur_partner   = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ids 0, replies on
		send_byte(SYNC_BYTE);
		send_byte(8'h00);
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(8'h00);
		send_byte(8'h01);
		frame_payload.push_back(8'hFF);
		send_frame(8'h00, 8'h00, 16'd0, 1'b0);
		frame_payload.push_back(8'h00);
		send_frame(8'h00, 8'h00, 16'd1, 1'b1);

		for (phase_no = 0; phase_no < 6; phase_no++) begin
			if (phase_no < 2) begin
				src_idle = 28;
				dst_idle = 53;
			end else if (phase_no < 4) begin
				src_idle = 53;
				dst_idle = 28;
			end else begin
				src_idle = 0;
				dst_idle = 0;
			end
			case (phase_no)
				0: set_config(8'h00, 8'hFF, 1'b1);
				1: set_config(8'hFF, 8'h00, 1'b0);
				2: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
				3: set_config(8'hFF, 8'hFF, 1'b0);
				4: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
			endcase
			target = sent_count + PHASE_BYTES;
			if (phase_no == 5) begin
				// length with a nonzero high byte, index past 255
				frame_payload.push_back(8'hFF);
				send_frame(cur_partner, cur_own, 16'd300, 1'b0);
			end
			while (sent_count < target) send_unit();
		end

		rx_ch.valid <= 1'b0;
		wait_idle();
		if (fail_count == 0) begin
			$display("PASS addressed_frame_receiver_top");
		end else begin
			$display("FAIL addressed_frame_receiver_top");
		end
		$finish;
	end

endmodule

// ===== addressed_frame_receiver_top.f =====
rtl/core/afr_pkg.sv
rtl/core/afr_in_if.sv
rtl/core/afr_out_if.sv
rtl/core/addressed_frame_receiver_top.sv
sim/afr_frame_checker.sv
sim/tb_top.sv
